// ===== hw/rtl/u8lat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lat_pkg
// Shared types and constants for the UTF-8 Latin diacritic to ASCII block.
// ----------------------------------------------------------------------------
package u8lat_pkg;

    localparam int OUT_CAPACITY = 64;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [7:0] B_NUL   = 8'h00;
    localparam logic [7:0] B_LEAD4 = 8'hC4;
    localparam logic [7:0] B_LEAD5 = 8'hC5;
    localparam logic [7:0] B_C_LO  = 8'h8D;
    localparam logic [7:0] B_C_LO2 = 8'h87;
    localparam logic [7:0] B_C_UP  = 8'h8C;
    localparam logic [7:0] B_C_UP2 = 8'h86;
    localparam logic [7:0] B_S_LO  = 8'hA1;
    localparam logic [7:0] B_S_UP  = 8'hA0;
    localparam logic [7:0] B_Z_LO  = 8'hBE;
    localparam logic [7:0] B_Z_UP  = 8'hBD;
    localparam logic [7:0] B_DJ_LO = 8'h91;
    localparam logic [7:0] B_DJ_UP = 8'h90;

    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_C_UP  = 7'h43;
    localparam logic [6:0] CH_D_UP  = 7'h44;
    localparam logic [6:0] CH_S_UP  = 7'h53;
    localparam logic [6:0] CH_Z_UP  = 7'h5A;
    localparam logic [6:0] CH_C_LO  = 7'h63;
    localparam logic [6:0] CH_D_LO  = 7'h64;
    localparam logic [6:0] CH_J_LO  = 7'h6A;
    localparam logic [6:0] CH_S_LO  = 7'h73;
    localparam logic [6:0] CH_Z_LO  = 7'h7A;
    localparam logic [6:0] CH_A_LO  = 7'h61;
    localparam logic [6:0] CASE_GAP = 7'h20;

    // one to two output characters produced by one input byte
    typedef struct packed {
        logic       two;
        logic [6:0] ch0;
        logic       last0;
        logic [6:0] ch1;
        logic       last1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/u8lat_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lat_front
// Accepts bytes, tracks held lead and string length, builds queue entries.
// ----------------------------------------------------------------------------
module u8lat_front #(
    parameter int OUT_CAPACITY = u8lat_pkg::OUT_CAPACITY
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_wdata,
    input  wire                   i_accept,
    input  wire  [7:0]            i_byte_in,
    output logic                  o_push,
    output u8lat_pkg::t_entry     o_entry
);

    localparam int CW = $clog2(OUT_CAPACITY);
    localparam logic [CW-1:0] CNT_FULL = CW'(OUT_CAPACITY - 1);
    localparam logic [CW-1:0] CNT_DJ   = CW'(OUT_CAPACITY - 2);

    typedef enum logic [2:0] {
        LEAD_NONE = 3'b001,
        LEAD_C4   = 3'b010,
        LEAD_C5   = 3'b100
    } t_lead;

    t_lead         r_lead, n_lead;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_upper;

    logic [6:0]    res_ch   [2];
    logic          res_last [2];
    logic [1:0]    nres;
    logic          done;
    logic          use0;
    logic          full0;
    logic          full_a;
    logic [CW-1:0] cnt_a;
    logic          f_emit;
    logic [6:0]    f_ch;

    function automatic logic [6:0] up_if(input logic [6:0] ch, input logic up);
        logic [6:0] r;
        r = ch;
        if (up && ch >= u8lat_pkg::CH_A_LO && ch <= u8lat_pkg::CH_Z_LO) begin
            r = ch - u8lat_pkg::CASE_GAP;
        end
        return r;
    endfunction

    always_comb begin
        n_lead      = LEAD_NONE;
        n_cnt       = r_cnt;
        res_ch[0]   = u8lat_pkg::CH_NUL;
        res_ch[1]   = u8lat_pkg::CH_NUL;
        res_last[0] = 1'b0;
        res_last[1] = 1'b0;
        nres        = 2'd0;
        done        = 1'b0;
        use0        = 1'b0;
        cnt_a       = r_cnt;
        full_a      = 1'b0;
        f_emit      = 1'b0;
        f_ch        = u8lat_pkg::CH_QMARK;
        full0       = (r_cnt >= CNT_FULL);

        if (i_byte_in == u8lat_pkg::B_NUL) begin
            n_cnt = '0;
            if (r_lead != LEAD_NONE && !full0) begin
                res_ch[0]   = u8lat_pkg::CH_QMARK;
                res_ch[1]   = u8lat_pkg::CH_NUL;
                res_last[1] = 1'b1;
                nres        = 2'd2;
            end else begin
                res_ch[0]   = u8lat_pkg::CH_NUL;
                res_last[0] = 1'b1;
                nres        = 2'd1;
            end
        end else begin
            if (r_lead != LEAD_NONE && !full0) begin
                unique case (r_lead)
                    LEAD_C4: begin
                        if (i_byte_in == u8lat_pkg::B_C_LO || i_byte_in == u8lat_pkg::B_C_LO2) begin
                            res_ch[0] = up_if(u8lat_pkg::CH_C_LO, r_upper);
                            nres = 2'd1;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_C_UP ||
                                     i_byte_in == u8lat_pkg::B_C_UP2) begin
                            res_ch[0] = u8lat_pkg::CH_C_UP;
                            nres = 2'd1;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_DJ_LO && r_cnt < CNT_DJ) begin
                            res_ch[0] = up_if(u8lat_pkg::CH_D_LO, r_upper);
                            res_ch[1] = up_if(u8lat_pkg::CH_J_LO, r_upper);
                            nres = 2'd2;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_DJ_UP && r_cnt < CNT_DJ) begin
                            res_ch[0] = u8lat_pkg::CH_D_UP;
                            res_ch[1] = u8lat_pkg::CH_J_LO;
                            nres = 2'd2;
                            done = 1'b1;
                        end
                    end
                    LEAD_C5: begin
                        if (i_byte_in == u8lat_pkg::B_S_LO) begin
                            res_ch[0] = up_if(u8lat_pkg::CH_S_LO, r_upper);
                            nres = 2'd1;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_S_UP) begin
                            res_ch[0] = u8lat_pkg::CH_S_UP;
                            nres = 2'd1;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_Z_LO) begin
                            res_ch[0] = up_if(u8lat_pkg::CH_Z_LO, r_upper);
                            nres = 2'd1;
                            done = 1'b1;
                        end else if (i_byte_in == u8lat_pkg::B_Z_UP) begin
                            res_ch[0] = u8lat_pkg::CH_Z_UP;
                            nres = 2'd1;
                            done = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (!done) begin
                    res_ch[0] = u8lat_pkg::CH_QMARK;
                    nres      = 2'd1;
                    use0      = 1'b1;
                    cnt_a     = r_cnt + CW'(1);
                end
            end

            if (!done) begin
                full_a = (cnt_a >= CNT_FULL);
                if (!full_a) begin
                    if (!i_byte_in[7]) begin
                        f_emit = 1'b1;
                        f_ch   = up_if(i_byte_in[6:0], r_upper);
                    end else if (i_byte_in == u8lat_pkg::B_LEAD4) begin
                        n_lead = LEAD_C4;
                    end else if (i_byte_in == u8lat_pkg::B_LEAD5) begin
                        n_lead = LEAD_C5;
                    end else begin
                        f_emit = 1'b1;
                    end
                end
                if (f_emit) begin
                    if (use0) begin
                        res_ch[1] = f_ch;
                        nres      = 2'd2;
                    end else begin
                        res_ch[0] = f_ch;
                        nres      = 2'd1;
                    end
                end
            end
            n_cnt = r_cnt + CW'(nres);
        end
    end

    always_comb begin
        o_push        = i_accept && (nres != 2'd0);
        o_entry.two   = (nres == 2'd2);
        o_entry.ch0   = res_ch[0];
        o_entry.last0 = res_last[0];
        o_entry.ch1   = res_ch[1];
        o_entry.last1 = res_last[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= LEAD_NONE;
            r_cnt   <= '0;
            r_upper <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_upper <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_lead <= n_lead;
                r_cnt  <= n_cnt;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/u8lat_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lat_fifo
// Short queue of character entries between front and back.
// ----------------------------------------------------------------------------
module u8lat_fifo #(
    parameter int FIFO_DEPTH = u8lat_pkg::FIFO_DEPTH
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire u8lat_pkg::t_entry  i_entry,
    input  wire                     i_pop,
    output u8lat_pkg::t_entry       o_entry,
    output u8lat_pkg::t_fifo_stat   o_stat
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int NW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [NW-1:0] NUM_FULL = NW'(FIFO_DEPTH);

    u8lat_pkg::t_entry r_mem [FIFO_DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [NW-1:0]     r_num;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_num <= r_num + NW'(1);
                2'b01:   r_num <= r_num - NW'(1);
                default: ;
            endcase
        end
    end

    assign o_entry      = r_mem[r_rp];
    assign o_stat.full  = (r_num == NUM_FULL);
    assign o_stat.empty = (r_num == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/u8lat_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8lat_back
// Unpacks queue entries into single characters on the output register.
// ----------------------------------------------------------------------------
module u8lat_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire u8lat_pkg::t_entry     i_entry,
    input  wire u8lat_pkg::t_fifo_stat i_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [6:0]                 o_char_out,
    output logic                       o_last
);

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       r_pend;
    logic [6:0] r_pchar;
    logic       r_plast;
    logic       load_free;

    assign load_free = !r_valid || i_ready;
    assign o_pop     = load_free && !r_pend && !i_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load_free) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_stat.empty;
                r_pend  <= !i_stat.empty && i_entry.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_free) begin
            if (r_pend) begin
                r_char <= r_pchar;
                r_last <= r_plast;
            end else begin
                r_char  <= i_entry.ch0;
                r_last  <= i_entry.last0;
                r_pchar <= i_entry.ch1;
                r_plast <= i_entry.last1;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_latin_diacritic_to_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_latin_diacritic_to_ascii
// UTF-8 Latin text to ASCII: diacritic letters map to base letters.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------
// input    | i_valid / o_ready    | i_byte_in[7:0]
// output   | o_valid / i_ready    | o_char_out[6:0], o_last
// config   | i_cfg_we             | i_cfg_wdata
//
// One byte accepted per cycle while the queue has room; one character leaves
// per cycle while the receiver is ready; a byte that yields two characters
// holds the back end for both. A character is registered in the queue and
// then in the output register. Reset is synchronous and clears lead, count,
// queue and mode. Either side may stall; the FIFO_DEPTH-entry queue absorbs it.
// ----------------------------------------------------------------------------
module utf8_latin_diacritic_to_ascii #(
    parameter int OUT_CAPACITY = u8lat_pkg::OUT_CAPACITY,
    parameter int FIFO_DEPTH   = u8lat_pkg::FIFO_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_byte_in,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [6:0] o_char_out,
    output logic       o_last
);

    u8lat_pkg::t_entry     push_entry;
    u8lat_pkg::t_entry     pop_entry;
    u8lat_pkg::t_fifo_stat fifo_stat;
    logic                  push;
    logic                  pop;
    logic                  accept;

    assign o_ready = !fifo_stat.full;
    assign accept  = i_valid && o_ready;

    u8lat_front #(
        .OUT_CAPACITY (OUT_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte_in   (i_byte_in),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    u8lat_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (fifo_stat)
    );

    u8lat_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (pop_entry),
        .i_stat     (fifo_stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !fifo_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty)
        else $error("queue pop while empty");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_char_out == u8lat_pkg::CH_NUL))
        else $error("terminator carries a nonzero character");

    a_entry_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_entry.two) |-> !push_entry.last0)
        else $error("terminator placed before a second character");
`endif

endmodule
`default_nettype wire

// ===== bench/utf8_latin_diacritic_to_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin_diacritic_to_ascii_tb
// Self-checking bench for the UTF-8 Latin diacritic to ASCII converter.
// A short table of directed bytes covers the byte extremes, several diacritic
// pair, mismatched pairs and a terminator after a held lead byte. Random
// strings follow: mostly well-formed text and pairs, some filled up to the
// string capacity, some plain noise. Each accepted byte runs through an
// in-bench transliterator whose characters are queued and compared against
// every output transfer. Sender bursts and receiver stalls are random, and
// the upper-case mode is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module utf8_latin_diacritic_to_ascii_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 250;

    typedef enum logic [1:0] {HELD_NONE, HELD_C4, HELD_C5} t_held;
    typedef enum logic {ROW_BYTE, ROW_MODE} t_row_kind;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] val;
        logic       typed;
        logic [1:0] n;
        logic [6:0] c0;
    } t_row;

    localparam logic [7:0] C4_TAIL [6] = '{u8lat_pkg::B_C_LO, u8lat_pkg::B_C_LO2,
                                           u8lat_pkg::B_C_UP, u8lat_pkg::B_C_UP2,
                                           u8lat_pkg::B_DJ_LO, u8lat_pkg::B_DJ_UP};
    localparam logic [7:0] C5_TAIL [4] = '{u8lat_pkg::B_S_LO, u8lat_pkg::B_S_UP,
                                           u8lat_pkg::B_Z_LO, u8lat_pkg::B_Z_UP};

    localparam int DIR_LEN = 28;
    localparam t_row DIR_ROWS [DIR_LEN] = '{
        '{ROW_BYTE, u8lat_pkg::B_NUL,   1'b1, 2'd1, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, 8'h61,              1'b1, 2'd1, u8lat_pkg::CH_A_LO},
        '{ROW_BYTE, 8'h7F,              1'b1, 2'd1, 7'h7F},
        '{ROW_BYTE, 8'h80,              1'b1, 2'd1, u8lat_pkg::CH_QMARK},
        '{ROW_BYTE, 8'hFF,              1'b1, 2'd1, u8lat_pkg::CH_QMARK},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_C_LO,  1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_C_UP,  1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD5, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_S_LO,  1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD5, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_Z_UP,  1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_DJ_LO, 1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_DJ_UP, 1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, 8'h41,              1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD5, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_NUL,   1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_MODE, 8'h01,              1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, 8'h7A,              1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_C_LO,  1'b0, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_LEAD4, 1'b1, 2'd0, u8lat_pkg::CH_NUL},
        '{ROW_BYTE, u8lat_pkg::B_DJ_LO, 1'b0, 2'd0, u8lat_pkg::CH_NUL}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_byte_in   = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [6:0] o_char_out;
    logic       o_last;

    // typed expectation travelling with the byte on the input channel
    logic       tx_typed = 1'b0;
    logic [1:0] tx_n     = 2'd0;
    logic [6:0] tx_c0    = u8lat_pkg::CH_NUL;

    // transliterator state
    logic       tl_mode;
    t_held      tl_held;
    int         tl_count;
    t_char      step_chars [2];
    int         step_n;

    t_char       pending_chars [$];
    logic [7:0]  str_q [$];
    int          err_count   = 0;
    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    int          rx_mode     = 0;
    int          rx_cnt      = 0;

    utf8_latin_diacritic_to_ascii i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_byte_in   (i_byte_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_out  (o_char_out),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void emit(logic [6:0] ch, logic lst);
        step_chars[step_n] = {ch, lst};
        step_n++;
        if (!lst) begin
            tl_count++;
        end
    endfunction

    function automatic logic [6:0] fold_case(logic [6:0] ch);
        if (tl_mode && ch >= u8lat_pkg::CH_A_LO && ch <= u8lat_pkg::CH_Z_LO) begin
            return ch - u8lat_pkg::CASE_GAP;
        end
        return ch;
    endfunction

    function automatic bit string_full();
        return tl_count >= u8lat_pkg::OUT_CAPACITY - 1;
    endfunction

    function automatic void translit_byte(logic [7:0] b);
        bit taken;
        taken  = 1'b0;
        step_n = 0;
        if (b == u8lat_pkg::B_NUL) begin
            if (tl_held != HELD_NONE && !string_full()) begin
                emit(u8lat_pkg::CH_QMARK, 1'b0);
            end
            emit(u8lat_pkg::CH_NUL, 1'b1);
            tl_held  = HELD_NONE;
            tl_count = 0;
            return;
        end
        if (tl_held != HELD_NONE && !string_full()) begin
            if (tl_held == HELD_C4) begin
                if (b == u8lat_pkg::B_C_LO || b == u8lat_pkg::B_C_LO2) begin
                    emit(fold_case(u8lat_pkg::CH_C_LO), 1'b0);
                    taken = 1'b1;
                end else if (b == u8lat_pkg::B_C_UP || b == u8lat_pkg::B_C_UP2) begin
                    emit(u8lat_pkg::CH_C_UP, 1'b0);
                    taken = 1'b1;
                end else if ((b == u8lat_pkg::B_DJ_LO || b == u8lat_pkg::B_DJ_UP) &&
                             tl_count < u8lat_pkg::OUT_CAPACITY - 2) begin
                    if (b == u8lat_pkg::B_DJ_LO) begin
                        emit(fold_case(u8lat_pkg::CH_D_LO), 1'b0);
                        emit(fold_case(u8lat_pkg::CH_J_LO), 1'b0);
                    end else begin
                        emit(u8lat_pkg::CH_D_UP, 1'b0);
                        emit(u8lat_pkg::CH_J_LO, 1'b0);
                    end
                    taken = 1'b1;
                end
            end else begin
                if (b == u8lat_pkg::B_S_LO) begin
                    emit(fold_case(u8lat_pkg::CH_S_LO), 1'b0);
                    taken = 1'b1;
                end else if (b == u8lat_pkg::B_S_UP) begin
                    emit(u8lat_pkg::CH_S_UP, 1'b0);
                    taken = 1'b1;
                end else if (b == u8lat_pkg::B_Z_LO) begin
                    emit(fold_case(u8lat_pkg::CH_Z_LO), 1'b0);
                    taken = 1'b1;
                end else if (b == u8lat_pkg::B_Z_UP) begin
                    emit(u8lat_pkg::CH_Z_UP, 1'b0);
                    taken = 1'b1;
                end
            end
            tl_held = HELD_NONE;
            if (taken) begin
                return;
            end
            emit(u8lat_pkg::CH_QMARK, 1'b0);
        end
        tl_held = HELD_NONE;
        if (string_full()) begin
            return;
        end
        if (!b[7]) begin
            emit(fold_case(b[6:0]), 1'b0);
        end else if (b == u8lat_pkg::B_LEAD4) begin
            tl_held = HELD_C4;
        end else if (b == u8lat_pkg::B_LEAD5) begin
            tl_held = HELD_C5;
        end else begin
            emit(u8lat_pkg::CH_QMARK, 1'b0);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_char want;
        if (!i_rst_n) begin
            tl_mode  = 1'b0;
            tl_held  = HELD_NONE;
            tl_count = 0;
            pending_chars.delete();
        end else begin
            if (i_cfg_we) begin
                tl_mode = i_cfg_wdata;
            end
            if (i_valid && o_ready) begin
                translit_byte(i_byte_in);
                if (tx_typed) begin
                    for (int i = 0; i < tx_n; i++) begin
                        pending_chars.push_back({tx_c0, tx_c0 == u8lat_pkg::CH_NUL});
                    end
                end else begin
                    for (int i = 0; i < step_n; i++) begin
                        pending_chars.push_back(step_chars[i]);
                    end
                end
            end
            if (o_valid && i_ready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, got char %h last %b",
                             $time, o_char_out, o_last);
                    err_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_char_out !== want.ch) begin
                        $display("%0t: char_out mismatch, expected %h, got %h",
                                 $time, want.ch, o_char_out);
                        err_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch, expected %b, got %b",
                                 $time, want.last, o_last);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rx_cnt == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_cnt  <= $urandom_range(40, 300);
        end else begin
            rx_cnt <= rx_cnt - 1;
        end
        case (rx_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_ready <= (rx_cnt % 5 != 0);
            end
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input logic [1:0] n, input logic [6:0] c0);
        i_valid   <= 1'b1;
        i_byte_in <= b;
        tx_typed  <= typed;
        tx_n      <= n;
        tx_c0     <= c0;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic pace(input bit calm);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_valid   <= 1'b0;
                i_byte_in <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_token();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            str_q.push_back(8'($urandom_range(1, 127)));
        end else if (r < 9) begin
            if ($urandom_range(0, 1) == 1) begin
                str_q.push_back(u8lat_pkg::B_LEAD4);
                str_q.push_back(C4_TAIL[$urandom_range(0, 5)]);
            end else begin
                str_q.push_back(u8lat_pkg::B_LEAD5);
                str_q.push_back(C5_TAIL[$urandom_range(0, 3)]);
            end
        end else begin
            str_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic build_string();
        int kind;
        int len;
        str_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            // noise and broken pairs
            len = $urandom_range(1, 12);
            repeat (len) begin
                if ($urandom_range(0, 2) == 0) begin
                    str_q.push_back($urandom_range(0, 1) ? u8lat_pkg::B_LEAD4
                                                         : u8lat_pkg::B_LEAD5);
                end
                str_q.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            len = $urandom_range(0, 16);
            if (kind >= 6) begin
                // fill toward capacity, often leaving room for one character
                len = $urandom_range(0, 1) ? u8lat_pkg::OUT_CAPACITY - 2
                                           : $urandom_range(u8lat_pkg::OUT_CAPACITY - 5,
                                                            u8lat_pkg::OUT_CAPACITY + 2);
                repeat (len) str_q.push_back(8'($urandom_range(1, 127)));
                if ($urandom_range(0, 1) == 1) begin
                    str_q.push_back(u8lat_pkg::B_LEAD4);
                    str_q.push_back($urandom_range(0, 1) ? u8lat_pkg::B_DJ_LO
                                                         : u8lat_pkg::B_DJ_UP);
                end
                len = $urandom_range(0, 4);
            end
            repeat (len) add_token();
        end
        if ($urandom_range(0, 9) != 0) begin
            str_q.push_back(u8lat_pkg::B_NUL);
        end
    endtask

    initial begin : stimulus
        int  phase_sent;
        bit  calm;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_MODE) begin
                drain_and_settle();
                write_mode(DIR_ROWS[r].val[0]);
            end else begin
                pace(1'b0);
                send_byte(DIR_ROWS[r].val, DIR_ROWS[r].typed, DIR_ROWS[r].n,
                          DIR_ROWS[r].c0);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_and_settle();
            write_mode(p[0]);
            calm = (p % 3 == 2);
            phase_sent = 0;
            while (phase_sent < PHASE_BYTES) begin
                build_string();
                foreach (str_q[k]) begin
                    pace(calm);
                    send_byte(str_q[k], 1'b0, 2'd0, u8lat_pkg::CH_NUL);
                    phase_sent++;
                end
            end
        end

        drain_and_settle();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
